[design/rup_pkg.sv]
// ---------------------------------------------------------------------------
// rup_pkg: shared types and constants for the radix unsigned parser
// Radix and status codes, register map, per-string state and digit decoding.
// ---------------------------------------------------------------------------
package rup_pkg;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Values of the radix_mode register.
  localparam logic [2:0] MODE_AUTO = 3'd0;
  localparam logic [2:0] MODE_BIN  = 3'd1;
  localparam logic [2:0] MODE_OCT  = 3'd2;
  localparam logic [2:0] MODE_DEC  = 3'd3;
  localparam logic [2:0] MODE_HEX  = 3'd4;

  // Register indexes on the configuration port.
  localparam logic REG_RADIX_MODE = 1'b0;
  localparam logic REG_ID_LIMIT   = 1'b1;

  localparam logic [31:0] ID_LIMIT_RESET = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_B    = 8'h62;
  localparam logic [7:0] CH_O    = 8'h6F;
  localparam logic [7:0] CH_X    = 8'h78;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  typedef struct packed {
    logic    valid;
    logic [3:0] value;
  } digit_t;

  // Per-string parser state, apart from the accumulator.
  typedef struct packed {
    logic [1:0] pos;
    radix_t     radix;
    status_t    fail;
    logic       seen;
    logic       prefix;
  } str_state_t;

  localparam str_state_t STR_CLEAR = '{
    pos:    POS_FIRST,
    radix:  RADIX_DEC,
    fail:   ST_OK,
    seen:   1'b0,
    prefix: 1'b0
  };

  function automatic logic [4:0] radix_base(input radix_t r);
    logic [4:0] b;
    case (r)
      RADIX_BIN: b = 5'd2;
      RADIX_OCT: b = 5'd8;
      RADIX_DEC: b = 5'd10;
      RADIX_HEX: b = 5'd16;
      default:   b = 5'd10;
    endcase
    return b;
  endfunction

  function automatic digit_t digit_of(input logic [7:0] c, input radix_t r);
    digit_t     d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c inside {[8'h30:8'h39]}) begin
      diff = c - 8'h30;
      d.valid = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      diff = c - 8'h57;
      d.valid = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      diff = c - 8'h37;
      d.valid = 1'b1;
    end
    d.value = diff[3:0];
    if ({1'b0, d.value} >= radix_base(r)) begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

[design/rup_step.sv]
// ---------------------------------------------------------------------------
// rup_step: next-state logic for one character
// Radix selection on the first character, prefix detection, digit decode and
// the multiply-add with overflow check, plus the status for a closing beat.
// ---------------------------------------------------------------------------
module rup_step #(
  parameter int VALUE_WIDTH = 32
) (
  input  rup_pkg::str_state_t   st,
  input  logic [VALUE_WIDTH-1:0] acc,
  input  logic [7:0]             char_code,
  input  logic                   is_last,
  input  logic [2:0]             radix_mode,
  output rup_pkg::str_state_t    st_next,
  output logic [VALUE_WIDTH-1:0] acc_next,
  output logic                   ok,
  output rup_pkg::status_t       status
);

  localparam int PW = VALUE_WIDTH + 4;

  logic               first;
  rup_pkg::radix_t    radix_eff;
  rup_pkg::status_t   fail_eff;
  logic               prefix_eff;
  logic               do_prefix;
  rup_pkg::digit_t    dig;
  logic [PW-1:0]      acc_w;
  logic [PW-1:0]      prod;
  logic               ovf;
  rup_pkg::status_t   st_fin;

  assign first = (st.pos == rup_pkg::POS_FIRST);

  always_comb begin
    radix_eff  = st.radix;
    fail_eff   = st.fail;
    prefix_eff = st.prefix;
    if (first) begin
      prefix_eff = 1'b0;
      fail_eff   = rup_pkg::ST_OK;
      case (radix_mode)
        rup_pkg::MODE_AUTO: begin
          radix_eff  = rup_pkg::RADIX_DEC;
          prefix_eff = (char_code == rup_pkg::CH_ZERO);
        end
        rup_pkg::MODE_BIN: radix_eff = rup_pkg::RADIX_BIN;
        rup_pkg::MODE_OCT: radix_eff = rup_pkg::RADIX_OCT;
        rup_pkg::MODE_DEC: radix_eff = rup_pkg::RADIX_DEC;
        rup_pkg::MODE_HEX: radix_eff = rup_pkg::RADIX_HEX;
        default: begin
          radix_eff = rup_pkg::RADIX_DEC;
          fail_eff  = rup_pkg::ST_INVALID;
        end
      endcase
    end
  end

  // A prefix letter counts only as the second character of a longer string.
  assign do_prefix = (st.pos == rup_pkg::POS_SECOND) && st.prefix && !is_last &&
                     (st.fail == rup_pkg::ST_OK) &&
                     (char_code == rup_pkg::CH_B || char_code == rup_pkg::CH_O ||
                      char_code == rup_pkg::CH_X);

  assign dig   = rup_pkg::digit_of(char_code, radix_eff);
  assign acc_w = PW'(acc);

  always_comb begin
    case (radix_eff)
      rup_pkg::RADIX_BIN: prod = acc_w << 1;
      rup_pkg::RADIX_OCT: prod = acc_w << 3;
      rup_pkg::RADIX_DEC: prod = (acc_w << 3) + (acc_w << 1);
      rup_pkg::RADIX_HEX: prod = acc_w << 4;
      default:            prod = acc_w << 3;
    endcase
    prod = prod + PW'(dig.value);
  end

  assign ovf = |prod[PW-1:VALUE_WIDTH];

  always_comb begin
    st_next        = st;
    st_next.radix  = radix_eff;
    st_next.fail   = fail_eff;
    st_next.prefix = prefix_eff;
    acc_next       = acc;
    if (st.pos != rup_pkg::POS_LATER) begin
      st_next.pos = st.pos + 2'd1;
    end
    if (do_prefix) begin
      case (char_code)
        rup_pkg::CH_B: st_next.radix = rup_pkg::RADIX_BIN;
        rup_pkg::CH_O: st_next.radix = rup_pkg::RADIX_OCT;
        default:       st_next.radix = rup_pkg::RADIX_HEX;
      endcase
      acc_next     = '0;
      st_next.seen = 1'b0;
    end else if (fail_eff == rup_pkg::ST_OK) begin
      if (!dig.valid) begin
        st_next.fail = rup_pkg::ST_INVALID;
      end else if (ovf) begin
        st_next.fail = rup_pkg::ST_OVERFLOW;
      end else begin
        acc_next     = prod[VALUE_WIDTH-1:0];
        st_next.seen = 1'b1;
      end
    end
  end

  always_comb begin
    st_fin = st_next.fail;
    if (st_fin == rup_pkg::ST_OK && !st_next.seen) begin
      st_fin = rup_pkg::ST_EMPTY;
    end
  end

  assign status = st_fin;
  assign ok     = (st_fin == rup_pkg::ST_OK);

endmodule

[design/radix_unsigned_parser_core.sv]
// ---------------------------------------------------------------------------
// radix_unsigned_parser_core: streaming ASCII unsigned integer parser
// Parses one string per result in binary, octal, decimal or hexadecimal,
// with optional 0b/0o/0x prefix detection and an id limit compare.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ---------------------------------------
//  char      char_valid / char_ready    char_code, is_last
//  result    result_valid / result_ready parse_ok, number, status, within_limit
//  config    APB (psel, penable, ...)   radix_mode @ 0x0, id_limit @ 0x4
//
// One character beat is taken per cycle while char_ready is high. A closing
// beat is registered in stage 1 after the digit step, then in the stage 2
// result register with the id limit compare.
// Reset clears the string state and both pipeline valids and resets the registers.
// A stalled result port backs up through the two stages; char_ready stays
// high as long as the first stage is empty or can move on.

module radix_unsigned_parser_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_code,
  input  logic        is_last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        parse_ok,
  output logic [31:0] number,
  output logic [1:0]  status,
  output logic        within_limit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  logic [2:0]  radix_mode;
  logic [31:0] id_limit;

  rup_pkg::str_state_t    st;
  rup_pkg::str_state_t    st_next;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_next;
  logic                   step_ok;
  rup_pkg::status_t       step_status;

  logic             r1_valid;
  logic             r1_ok;
  rup_pkg::status_t r1_status;
  logic [CW-1:0]    r1_acc;

  logic char_fire;
  logic s1_ready;
  logic s2_ready;
  logic cfg_write;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= rup_pkg::MODE_AUTO;
      id_limit   <= rup_pkg::ID_LIMIT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == rup_pkg::REG_RADIX_MODE) begin
        radix_mode <= pwdata[2:0];
      end else begin
        id_limit <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == rup_pkg::REG_ID_LIMIT) ? id_limit : {29'd0, radix_mode};

  // Handshake.
  assign s2_ready   = !result_valid || result_ready;
  assign s1_ready   = !r1_valid || s2_ready;
  assign char_ready = s1_ready;
  assign char_fire  = char_valid && char_ready;

  rup_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .st         (st),
    .acc        (acc),
    .char_code  (char_code),
    .is_last    (is_last),
    .radix_mode (radix_mode),
    .st_next    (st_next),
    .acc_next   (acc_next),
    .ok         (step_ok),
    .status     (step_status)
  );

  // String state returns to its cleared value after the closing beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= rup_pkg::STR_CLEAR;
      acc <= '0;
    end else if (char_fire) begin
      if (is_last) begin
        st  <= rup_pkg::STR_CLEAR;
        acc <= '0;
      end else begin
        st  <= st_next;
        acc <= acc_next;
      end
    end
  end

  // Stage 1: finished string.
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (s1_ready) begin
      r1_valid <= char_fire && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && char_fire && is_last) begin
      r1_ok     <= step_ok;
      r1_status <= step_status;
      r1_acc    <= CW'(acc_next);
    end
  end

  // Stage 2: result register with the id limit compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_ready) begin
      result_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && r1_valid) begin
      parse_ok     <= r1_ok;
      number       <= r1_acc[31:0];
      status       <= r1_status;
      within_limit <= r1_ok && (r1_acc < CW'(id_limit));
    end
  end

  a_ok_matches_status : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (parse_ok == (status == rup_pkg::ST_OK)))
    else $error("parse_ok disagrees with status");

  a_limit_needs_ok : assert property (@(posedge clk) disable iff (rst)
    (result_valid && within_limit) |-> parse_ok)
    else $error("within_limit set on a failed parse");

  a_stage1_from_last : assert property (@(posedge clk) disable iff (rst)
    char_fire |=> (r1_valid == $past(is_last)))
    else $error("stage 1 valid does not follow the closing beat");

  a_pos_saturates : assert property (@(posedge clk) disable iff (rst)
    st.pos != 2'd3)
    else $error("character position ran past saturation");

endmodule
